FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the quantizer modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define AIQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define AIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/aiq_pkg.sv
package aiq_pkg;

	// Mantissa, quotient and remainder widths of the divider.
	localparam int MANT_W = 24;
	localparam int QUO_W = MANT_W + 1;
	localparam int REM_W = MANT_W + 2;
	localparam int EXP_W = 10;

	// Divider split: stages times steps covers every quotient bit.
	localparam int DIV_STAGES = 5;
	localparam int DIV_STEPS = 5;

	// Fixed-point magnitude used for the half-away rounding (25 fraction bits).
	localparam int FX_W = 35;
	localparam int FX_FRAC = 25;
	localparam int MAG_W = 9;

	// Pipeline depth: two unpack stages, the divider, three rounding stages, output.
	localparam int NSTAGE = 2 + DIV_STAGES + 3 + 1;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZP = 2'd1;
	localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

	// What the word resolves to: a real quotient, the zero point alone, or saturation.
	typedef enum logic [1:0] {
		CLS_NUM,
		CLS_ZP,
		CLS_SAT
	} cls_t;

	// Word travelling through the divider stages.
	typedef struct packed {
		logic sign;
		cls_t cls;
		logic signed [EXP_W-1:0] ex;
		logic [MANT_W-1:0] dvs;
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_t;

	// Rounded magnitude handed to the output stage.
	typedef struct packed {
		logic sign;
		logic [MAG_W-1:0] mag;
	} rnd_t;

	// Leading zero count of a 24-bit mantissa.
	function automatic logic [4:0] lzc24(input logic [MANT_W-1:0] m);
		logic [4:0] n;
		logic found;
		n = 5'd0;
		found = 1'b0;
		for (int i = MANT_W - 1; i >= 0; i--) begin
			if (!found && !m[i]) begin
				n = n + 5'd1;
			end else begin
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

FILE: rtl/core/aiq_unpack.sv
module aiq_unpack (
	input logic clk,
	input logic en_s1,
	input logic en_s2,
	input logic [31:0] sample_bits,
	input logic [31:0] scale_bits,
	output aiq_pkg::div_t dq
);
	import aiq_pkg::*;

	logic [7:0] ex_raw, es_raw;
	logic [22:0] fx_raw, fs_raw;
	logic x_zero, x_inf, x_nan, s_zero, s_inf, s_nan;
	logic [MANT_W-1:0] mx_raw, ms_raw;
	logic [4:0] lzx, lzs;
	logic signed [EXP_W-1:0] ex_d, es_d;
	cls_t cls_d;

	logic sign_s1;
	cls_t cls_s1;
	logic [MANT_W-1:0] mx_s1, ms_s1;
	logic signed [EXP_W-1:0] ex_s1, es_s1;

	logic signed [EXP_W-1:0] ediff, eq;
	logic lt;
	cls_t cls2;
	div_t dq_s2;

	// Field decode and operand classification.
	always_comb begin
		ex_raw = sample_bits[30:23];
		fx_raw = sample_bits[22:0];
		es_raw = scale_bits[30:23];
		fs_raw = scale_bits[22:0];
		x_zero = (ex_raw == 8'd0) && (fx_raw == 23'd0);
		x_inf = (ex_raw == 8'hFF) && (fx_raw == 23'd0);
		x_nan = (ex_raw == 8'hFF) && (fx_raw != 23'd0);
		s_zero = (es_raw == 8'd0) && (fs_raw == 23'd0);
		s_inf = (es_raw == 8'hFF) && (fs_raw == 23'd0);
		s_nan = (es_raw == 8'hFF) && (fs_raw != 23'd0);
		if (s_zero || x_nan || s_nan || (x_inf && s_inf) || s_inf || x_zero) begin
			cls_d = CLS_ZP;
		end else if (x_inf) begin
			cls_d = CLS_SAT;
		end else begin
			cls_d = CLS_NUM;
		end
	end

	// Normalize both mantissas so that subnormals look like normals.
	always_comb begin
		mx_raw = {ex_raw != 8'd0, fx_raw};
		ms_raw = {es_raw != 8'd0, fs_raw};
		lzx = lzc24(mx_raw);
		lzs = lzc24(ms_raw);
		ex_d = (ex_raw == 8'd0) ? -10'sd126 : ($signed({2'b00, ex_raw}) - 10'sd127);
		es_d = (es_raw == 8'd0) ? -10'sd126 : ($signed({2'b00, es_raw}) - 10'sd127);
		ex_d = ex_d - $signed({5'd0, lzx});
		es_d = es_d - $signed({5'd0, lzs});
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sign_s1 <= sample_bits[31] ^ scale_bits[31];
			cls_s1 <= cls_d;
			mx_s1 <= mx_raw << lzx;
			ms_s1 <= ms_raw << lzs;
			ex_s1 <= ex_d;
			es_s1 <= es_d;
		end
	end

	// Align the dividend so the quotient lands in [1,2) and screen the exponent.
	always_comb begin
		lt = mx_s1 < ms_s1;
		ediff = ex_s1 - es_s1;
		eq = lt ? (ediff - 10'sd1) : ediff;
		cls2 = cls_s1;
		if (cls_s1 == CLS_NUM) begin
			if (eq >= 10'sd8) begin
				cls2 = CLS_SAT;
			end else if (eq <= -10'sd3) begin
				cls2 = CLS_ZP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dq_s2.sign <= sign_s1;
			dq_s2.cls <= cls2;
			dq_s2.ex <= eq;
			dq_s2.dvs <= ms_s1;
			dq_s2.rem <= lt ? {1'b0, mx_s1, 1'b0} : {2'b00, mx_s1};
			dq_s2.quo <= '0;
		end
	end

	assign dq = dq_s2;

endmodule

FILE: rtl/core/aiq_div_stage.sv
`include "assert_macros.svh"

module aiq_div_stage (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld,
	input aiq_pkg::div_t d_in,
	output aiq_pkg::div_t d_out
);
	import aiq_pkg::*;

	div_t d_nx;
	div_t d_s;
	logic [REM_W-1:0] lim;

	// Restoring division, a fixed number of quotient bits per stage.
	always_comb begin
		d_nx = d_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (d_nx.rem >= {2'b00, d_nx.dvs}) begin
				d_nx.quo = {d_nx.quo[QUO_W-2:0], 1'b1};
				d_nx.rem = d_nx.rem - {2'b00, d_nx.dvs};
			end else begin
				d_nx.quo = {d_nx.quo[QUO_W-2:0], 1'b0};
			end
			d_nx.rem = {d_nx.rem[REM_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s <= d_nx;
		end
	end

	assign d_out = d_s;
	assign lim = {1'b0, d_s.dvs, 1'b0};

	// The partial remainder stays below twice the divisor.
	`AIQ_ASSERT_IMPL(a_rem_bound, vld && (d_s.cls == CLS_NUM), d_s.rem < lim, "remainder out of range")

endmodule

FILE: rtl/core/aiq_round.sv
`include "assert_macros.svh"

module aiq_round (
	input logic clk,
	input logic arst_n,
	input logic vld_in,
	input logic en_s8,
	input logic en_s9,
	input logic en_s10,
	input aiq_pkg::div_t d_in,
	output aiq_pkg::rnd_t r_out
);
	import aiq_pkg::*;

	logic [MANT_W-1:0] m24;
	logic rnd_up;
	logic [MANT_W:0] m25;
	logic signed [EXP_W-1:0] sh_w;
	logic [3:0] sh;

	logic sign_s8, sign_s9;
	cls_t cls_s8, cls_s9;
	logic [FX_W-1:0] a_s8;

	logic [FX_W-1:0] sum_d;
	logic [3:0] lsb_d;

	logic [FX_W-1:0] sum_s9;
	logic [3:0] lsb_s9;

	logic [FX_W-1:0] lowmask, half, remv, trunc, rsum;
	logic up2;
	logic [FX_W-FX_FRAC-1:0] ipart;
	logic [MAG_W-1:0] mag_d;
	rnd_t r_s10;

	// Round the quotient to float32 and place it on a fixed-point grid.
	always_comb begin
		m24 = d_in.quo[QUO_W-1:1];
		rnd_up = d_in.quo[0] && ((d_in.rem != '0) || m24[0]);
		m25 = {1'b0, m24} + {{MANT_W{1'b0}}, rnd_up};
		sh_w = d_in.ex + 10'sd2;
		sh = sh_w[3:0];
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			sign_s8 <= d_in.sign;
			cls_s8 <= d_in.cls;
			a_s8 <= {{(FX_W-MANT_W-1){1'b0}}, m25} << sh;
		end
	end

	// Add one half and find the lowest kept bit of the float32 sum.
	always_comb begin
		sum_d = a_s8 + (FX_W'(1) << (FX_FRAC - 1));
		lsb_d = 4'd1;
		for (int b = FX_FRAC - 1; b < FX_W - 1; b++) begin
			if (sum_d[b]) begin
				lsb_d = 4'(b - (MANT_W - 1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			sign_s9 <= sign_s8;
			cls_s9 <= cls_s8;
			sum_s9 <= sum_d;
			lsb_s9 <= lsb_d;
		end
	end

	// Round the sum to nearest even at its last kept bit, then truncate.
	always_comb begin
		lowmask = (FX_W'(1) << lsb_s9) - FX_W'(1);
		half = FX_W'(1) << (lsb_s9 - 4'd1);
		remv = sum_s9 & lowmask;
		trunc = sum_s9 & ~lowmask;
		up2 = (remv > half) || ((remv == half) && sum_s9[lsb_s9]);
		rsum = up2 ? (trunc + (FX_W'(1) << lsb_s9)) : trunc;
		ipart = rsum[FX_W-1:FX_FRAC];
		case (cls_s9)
			CLS_NUM: begin
				mag_d = (ipart >= 10'd256) ? 9'd256 : ipart[MAG_W-1:0];
			end
			CLS_SAT: begin
				mag_d = 9'd256;
			end
			default: begin
				mag_d = 9'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			r_s10.sign <= sign_s9;
			r_s10.mag <= mag_d;
		end
	end

	assign r_out = r_s10;

	// A finished quotient is normalized: its leading bit is set.
	`AIQ_ASSERT_IMPL(a_quo_norm, vld_in && (d_in.cls == CLS_NUM), d_in.quo[QUO_W-1], "quotient not normalized")

endmodule

FILE: rtl/core/affine_int8_quantizer_top.sv
// Affine int8 quantizer: each accepted word is a float32 element, divided by the float32
// scale register with round-to-nearest-even, rounded half away from zero, offset by the
// zero point and saturated to -128..127. The block takes one word per cycle while in_stall
// is low, and each word passes through two unpack/normalize stages, five divider stages of
// five quotient bits each, three rounding stages and the output register. Each stage
// moves on its own ready, so bubbles close up under output stall. Registers (index 0 scale,
// index 1 zero point) may only be written while no word is in flight.
`include "assert_macros.svh"

module affine_int8_quantizer_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [aiq_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [aiq_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] sample_bits,
	output logic out_valid,
	input logic out_stall,
	output logic signed [7:0] quantized
);
	import aiq_pkg::*;

	logic [31:0] scale_q;
	logic signed [7:0] zp_q;
	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] rdy;
	logic [NSTAGE-1:0] vin;
	div_t dbus [0:DIV_STAGES];
	rnd_t rnd;
	logic signed [10:0] sval, ssum;
	logic signed [7:0] qsat;
	logic signed [7:0] quantized_s11;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			zp_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE: begin
					scale_q <= cfg_data[31:0];
				end
				REG_ZP: begin
					zp_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A stage takes a new word when it is empty or its word moves on.
	always_comb begin
		rdy[NSTAGE] = !vld_q[NSTAGE] || !out_stall;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vin = {vld_q[NSTAGE-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k-1];
				end
			end
		end
	end

	assign in_stall = !rdy[1];

	aiq_unpack u_unpack (
		.clk(clk),
		.en_s1(rdy[1]),
		.en_s2(rdy[2]),
		.sample_bits(sample_bits),
		.scale_bits(scale_q),
		.dq(dbus[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		aiq_div_stage u_div (
			.clk(clk),
			.arst_n(arst_n),
			.en(rdy[3+i]),
			.vld(vld_q[3+i]),
			.d_in(dbus[i]),
			.d_out(dbus[i+1])
		);
	end

	aiq_round u_round (
		.clk(clk),
		.arst_n(arst_n),
		.vld_in(vld_q[2+DIV_STAGES]),
		.en_s8(rdy[3+DIV_STAGES]),
		.en_s9(rdy[4+DIV_STAGES]),
		.en_s10(rdy[5+DIV_STAGES]),
		.d_in(dbus[DIV_STAGES]),
		.r_out(rnd)
	);

	// Apply the sign, add the zero point and saturate to int8.
	always_comb begin
		sval = rnd.sign ? -$signed({2'b00, rnd.mag}) : $signed({2'b00, rnd.mag});
		ssum = sval + {{3{zp_q[7]}}, zp_q};
		if (ssum > 11'sd127) begin
			qsat = 8'sd127;
		end else if (ssum < -11'sd128) begin
			qsat = -8'sd128;
		end else begin
			qsat = ssum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NSTAGE]) begin
			quantized_s11 <= qsat;
		end
	end

	assign quantized = quantized_s11;
	assign out_valid = vld_q[NSTAGE];

	// An accepted word always occupies the first stage on the next cycle.
	`AIQ_ASSERT_NEXT(a_accept_s1, in_valid && !in_stall, vld_q[1], "accepted word lost")

endmodule
